/* hdl/fisher_yates_shuffle_engine_macros.svh */
// assertion macros for the shuffle engine
`ifndef FISHER_YATES_SHUFFLE_ENGINE_MACROS_SVH
`define FISHER_YATES_SHUFFLE_ENGINE_MACROS_SVH
`ifndef ASSERT_OFF
`define FYS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define FYS_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define FYS_ASSERT(label, clk, rst, prop, msg)
`define FYS_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

/* hdl/fys_pkg.sv */
package fys_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int POS_W       = $clog2(MAX_ENTRIES + 1);
  localparam int ENTRY_W     = 6;
  localparam int RAND_W      = 31;
  localparam int CNT_W       = $clog2(RAND_W + 1);
  localparam int CFG_W       = 7;

  localparam logic [1:0] ACT_RESTART = 2'd0;
  localparam logic [1:0] ACT_STEP    = 2'd1;
  localparam logic [1:0] ACT_READ    = 2'd2;

  localparam logic [1:0] REG_DECK_SIZE     = 2'd0;
  localparam logic [1:0] REG_SHUFFLE_MODE  = 2'd1;
  localparam logic [1:0] REG_PARTIAL_COUNT = 2'd2;

  localparam logic [CFG_W-1:0] DECK_SIZE_RST     = 7'd54;
  localparam logic [CFG_W-1:0] PARTIAL_COUNT_RST = 7'd16;

  typedef struct packed {
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ENTRY_W-1:0] wr_data;
    logic               clear;
  } store_req_t;

endpackage

/* hdl/fys_modred.sv */
module fys_modred (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [fys_pkg::RAND_W-1:0] dividend,
  input  logic [fys_pkg::POS_W-1:0]  divisor,
  output logic                       busy,
  output logic [fys_pkg::POS_W-1:0]  rem
);

  logic [fys_pkg::RAND_W-1:0] sh;
  logic [fys_pkg::POS_W-1:0]  d;
  logic [fys_pkg::CNT_W-1:0]  cnt;
  logic [fys_pkg::POS_W-1:0]  t;

  // remainder stays below the divisor, so its top bit is free for the shift
  assign t    = {rem[fys_pkg::POS_W-2:0], sh[fys_pkg::RAND_W-1]};
  assign busy = (cnt != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= fys_pkg::CNT_W'(fys_pkg::RAND_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= dividend;
      d   <= divisor;
      rem <= '0;
    end else if (busy) begin
      sh  <= {sh[fys_pkg::RAND_W-2:0], 1'b0};
      rem <= (t >= d) ? t - d : t;
    end
  end

endmodule

/* hdl/fys_store.sv */
module fys_store (
  input  logic                        clk,
  input  logic                        rst,
  input  fys_pkg::store_req_t         req,
  output logic [fys_pkg::ENTRY_W-1:0] rd_data
);

  logic [fys_pkg::ENTRY_W-1:0]     mem [fys_pkg::MAX_ENTRIES];
  logic [fys_pkg::MAX_ENTRIES-1:0] vld;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // an entry never written since restart reads as its own index
  always_ff @(posedge clk) begin
    if (vld[req.rd_addr]) begin
      rd_data <= mem[req.rd_addr];
    end else begin
      rd_data <= fys_pkg::ENTRY_W'(req.rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || req.clear) begin
      vld <= '0;
    end else if (req.wr_en) begin
      vld[req.wr_addr] <= 1'b1;
    end
  end

endmodule

/* hdl/fisher_yates_shuffle_engine.sv */
// Fisher-Yates shuffle engine over a store of up to 64 six-bit entries.
// Requests enter on s_axis: tuser carries the action (restart, step, read),
// tdata the random word and the read index. Every request gives exactly one
// result on m_axis: the entry read or placed, the finished flag and the
// ignored flag. Configuration writes go through cfg_valid/cfg_index/cfg_data
// and are taken at any time; they are meant for when the block is idle.
// A step passes the bit-serial remainder unit (one random bit per cycle,
// then the divide state sees it finish), the swap through the single read
// and single write port of the store and the output register. A read
// passes the read state and waits in the output state for the store data;
// a restart, an ignored step or an unused action go straight to output.
// One request is in work at a time; the next one is taken as soon as the
// previous result sits in the output register, even if the receiver has not
// taken it yet. While the receiver stalls a finished result, the block
// holds the next one and stops taking requests.
// Reset clears all valid bits of the store so that it reads as the identity
// order, ends the walk and loads the default register values.
`include "fisher_yates_shuffle_engine_macros.svh"

module fisher_yates_shuffle_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // random_value[30:0], read_index[36:31]
  input  logic [1:0]  s_axis_tuser,   // action[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // entry_value[5:0], finished[6], ignored[7]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_RDP  = 3'd2;
  localparam logic [2:0] S_RDJ  = 3'd3;
  localparam logic [2:0] S_WRP  = 3'd4;
  localparam logic [2:0] S_WRJ  = 3'd5;
  localparam logic [2:0] S_RDX  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  localparam int PW = fys_pkg::POS_W;
  localparam int AW = fys_pkg::ADDR_W;
  localparam int EW = fys_pkg::ENTRY_W;

  logic [2:0]                state;
  logic [fys_pkg::CFG_W-1:0] deck_size;
  logic                      shuffle_mode;
  logic [fys_pkg::CFG_W-1:0] partial_count;
  logic [PW-1:0]             walk_position;
  logic                      walk_done;
  logic [PW-1:0]             j;
  logic [EW-1:0]             a_val;
  logic [EW-1:0]             res_value;
  logic                      res_flag;
  logic                      rd_pending;
  logic [5:0]                ridx;

  logic [PW-1:0]             n_eff;
  logic [PW-1:0]             pc_eff;
  logic                      step_ok;
  logic [PW-1:0]             divisor;
  logic                      in_acc;
  logic                      out_load;
  logic                      md_busy;
  logic [PW-1:0]             md_rem;
  logic [EW-1:0]             st_rdata;
  fys_pkg::store_req_t       st_req;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state == S_OUT) && !rd_pending && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    if (32'(deck_size) < 32'd2) begin
      n_eff = PW'(2);
    end else if (32'(deck_size) > 32'(fys_pkg::MAX_ENTRIES)) begin
      n_eff = PW'(fys_pkg::MAX_ENTRIES);
    end else begin
      n_eff = PW'(deck_size);
    end
    if (32'(partial_count) > 32'(n_eff)) begin
      pc_eff = n_eff;
    end else begin
      pc_eff = PW'(partial_count);
    end
    if (!shuffle_mode) begin
      step_ok = !walk_done && (walk_position >= PW'(1)) &&
                (walk_position <= n_eff - PW'(1));
      divisor = walk_position + PW'(1);
    end else begin
      step_ok = !walk_done && (walk_position < pc_eff);
      divisor = n_eff - walk_position;
    end
  end

  always_comb begin
    st_req         = '0;
    st_req.clear   = in_acc && (s_axis_tuser == fys_pkg::ACT_RESTART);
    st_req.rd_addr = AW'(walk_position);
    unique case (state)
      S_RDJ:   st_req.rd_addr = AW'(j);
      S_RDX:   st_req.rd_addr = AW'(ridx);
      S_WRP: begin
        st_req.wr_en   = 1'b1;
        st_req.wr_addr = AW'(walk_position);
        st_req.wr_data = st_rdata;
      end
      S_WRJ: begin
        st_req.wr_en   = 1'b1;
        st_req.wr_addr = AW'(j);
        st_req.wr_data = a_val;
      end
      default: st_req.rd_addr = AW'(walk_position);
    endcase
  end

  fys_modred u_modred (
    .clk      (clk),
    .rst      (rst),
    .start    (in_acc && (s_axis_tuser == fys_pkg::ACT_STEP) && step_ok),
    .dividend (s_axis_tdata[fys_pkg::RAND_W-1:0]),
    .divisor  (divisor),
    .busy     (md_busy),
    .rem      (md_rem)
  );

  fys_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (st_req),
    .rd_data (st_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      deck_size     <= fys_pkg::DECK_SIZE_RST;
      shuffle_mode  <= 1'b0;
      partial_count <= fys_pkg::PARTIAL_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      priority case (cfg_index)
        fys_pkg::REG_DECK_SIZE:     deck_size     <= cfg_data;
        fys_pkg::REG_SHUFFLE_MODE:  shuffle_mode  <= cfg_data[0];
        fys_pkg::REG_PARTIAL_COUNT: partial_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      walk_position <= '0;
      walk_done     <= 1'b1;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            res_value  <= '0;
            res_flag   <= (s_axis_tuser == fys_pkg::ACT_STEP) && !step_ok;
            rd_pending <= 1'b0;
            ridx       <= s_axis_tdata[36:31];
            if ((s_axis_tuser == fys_pkg::ACT_STEP) && step_ok) begin
              state <= S_DIV;
            end else if (s_axis_tuser == fys_pkg::ACT_READ) begin
              state <= S_RDX;
            end else begin
              state <= S_OUT;
            end
            if (s_axis_tuser == fys_pkg::ACT_RESTART) begin
              if (!shuffle_mode) begin
                walk_position <= n_eff - PW'(1);
                walk_done     <= 1'b0;
              end else begin
                walk_position <= '0;
                walk_done     <= (pc_eff == '0);
              end
            end else if ((s_axis_tuser == fys_pkg::ACT_STEP) && !step_ok) begin
              walk_done <= 1'b1;
            end
          end
        end
        S_DIV: begin
          if (!md_busy) begin
            state <= S_RDP;
          end
        end
        S_RDP: begin
          j     <= shuffle_mode ? walk_position + md_rem : md_rem;
          state <= S_RDJ;
        end
        S_RDJ: begin
          a_val <= st_rdata;
          state <= S_WRP;
        end
        S_WRP: begin
          res_value <= st_rdata;
          state     <= S_WRJ;
        end
        S_WRJ: begin
          if (!shuffle_mode) begin
            walk_position <= walk_position - PW'(1);
            walk_done     <= (walk_position == PW'(1));
          end else begin
            walk_position <= walk_position + PW'(1);
            walk_done     <= (walk_position + PW'(1) >= pc_eff);
          end
          state <= S_OUT;
        end
        S_RDX: begin
          rd_pending <= 1'b1;
          state      <= S_OUT;
        end
        S_OUT: begin
          if (rd_pending) begin
            res_value  <= st_rdata;
            rd_pending <= 1'b0;
          end else if (out_load) begin
            m_axis_tdata <= {res_flag, walk_done, res_value};
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `FYS_ASSERT(a_accept_starts_work, clk, rst, in_acc |=> (state != S_IDLE), "request accepted but engine idle")
  `FYS_ASSERT_NEVER(a_write_outside_swap, clk, rst, st_req.wr_en && !(state == S_WRP || state == S_WRJ), "store written outside swap")
  `FYS_ASSERT(a_ignored_means_finished, clk, rst, (m_axis_tvalid && m_axis_tdata[7]) |-> m_axis_tdata[6], "ignored step without finished walk")
  `FYS_ASSERT(a_div_runs_in_div, clk, rst, md_busy |-> (state == S_DIV), "remainder unit busy outside divide state")

endmodule

/* bench/tb_fisher_yates_shuffle_engine.sv */
module tb_fisher_yates_shuffle_engine;
  import fys_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 40;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 400;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 180;

  typedef struct packed {
    logic [ENTRY_W-1:0] entry;
    logic               finished;
    logic               ignored;
  } result_t;

  typedef struct packed {
    bit                 is_cfg;
    logic [1:0]         reg_idx;
    logic [CFG_W-1:0]   reg_val;
    logic [1:0]         act;
    logic [RAND_W-1:0]  rnd;
    logic [ADDR_W-1:0]  ridx;
    bit                 typed;
    logic [ENTRY_W-1:0] entry;
    logic               finished;
    logic               ignored;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;   // random_value[30:0], read_index[36:31]
  logic [1:0]  s_axis_tuser = '0;   // action[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;        // entry_value[5:0], finished[6], ignored[7]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [6:0]  cfg_data = '0;

  // shadow of the block state
  logic [ENTRY_W-1:0] perm_model [MAX_ENTRIES];
  int unsigned        walk_pos;
  bit                 walk_done;
  logic [CFG_W-1:0]   deck_reg;
  bit                 mode_reg;
  logic [CFG_W-1:0]   count_reg;

  result_t owed_results [$];

  int send_gap_pct = 13;
  int recv_gap_pct = 69;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int errors = 0;
  int accepted_items = 0;
  int swaps_done = 0;
  int ignored_steps = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int holds_done = 0;

  fisher_yates_shuffle_engine DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned deck_entries();
    if (deck_reg < 2) return 2;
    if (deck_reg > MAX_ENTRIES) return MAX_ENTRIES;
    return deck_reg;
  endfunction

  function automatic int unsigned walk_limit(input int unsigned n);
    return (count_reg > n) ? n : count_reg;
  endfunction

  function automatic result_t apply_shuffle_request(input logic [1:0] act,
                                                     input logic [RAND_W-1:0] rnd,
                                                     input logic [ADDR_W-1:0] ridx);
    int unsigned n;
    int unsigned pc;
    int unsigned pos;
    int unsigned j;
    int k;
    logic [ENTRY_W-1:0] tmp;
    result_t r;
    n = deck_entries();
    pc = walk_limit(n);
    r = '0;
    case (act)
      ACT_RESTART: begin
        for (k = 0; k < MAX_ENTRIES; k++) perm_model[k] = k[ENTRY_W-1:0];
        if (!mode_reg) begin
          walk_pos = n - 1;
          walk_done = 1'b0;
        end else begin
          walk_pos = 0;
          walk_done = (pc == 0);
        end
      end
      ACT_STEP: begin
        pos = walk_pos;
        if (walk_done || (mode_reg ? (pos >= pc) : (pos < 1 || pos > n - 1))) begin
          walk_done = 1'b1;
          r.ignored = 1'b1;
        end else begin
          j = mode_reg ? pos + rnd % (n - pos) : rnd % (pos + 1);
          tmp = perm_model[pos];
          perm_model[pos] = perm_model[j];
          perm_model[j] = tmp;
          r.entry = perm_model[pos];
          if (!mode_reg) begin
            walk_pos = pos - 1;
            if (walk_pos == 0) walk_done = 1'b1;
          end else begin
            walk_pos = pos + 1;
            if (walk_pos >= pc) walk_done = 1'b1;
          end
        end
      end
      ACT_READ: r.entry = perm_model[ridx];
      default: ;
    endcase
    r.finished = walk_done;
    return r;
  endfunction

  task automatic send_request(input logic [1:0] act, input logic [RAND_W-1:0] rnd,
                              input logic [ADDR_W-1:0] ridx, input bit typed,
                              input result_t typed_res);
    result_t res;
    if ($urandom_range(0, 99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, ridx, rnd};
    s_axis_tuser  <= act;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    res = apply_shuffle_request(act, rnd, ridx);
    owed_results.push_back(typed ? typed_res : res);
    if (act == ACT_STEP && res.ignored) ignored_steps++;
    else accepted_items++;
    if (act == ACT_STEP && !res.ignored) swaps_done++;
  endtask

  task automatic drain_requests();
    s_axis_tvalid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [CFG_W-1:0] val);
    drain_requests();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DECK_SIZE:     deck_reg = val;
      REG_SHUFFLE_MODE:  mode_reg = val[0];
      REG_PARTIAL_COUNT: count_reg = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  // result side: random stalls, long hold-off on request, compare
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (owed_results.size() == 0) begin
        $error("result with no request outstanding: tdata %h", m_axis_tdata);
        errors++;
      end else begin
        want = owed_results.pop_front();
        results_checked++;
        if (m_axis_tdata[5:0] !== want.entry) begin
          $error("entry_value: expected %0d, got %0d", want.entry, m_axis_tdata[5:0]);
          errors++;
        end
        if (m_axis_tdata[6] !== want.finished) begin
          $error("finished: expected %0d, got %0d", want.finished, m_axis_tdata[6]);
          errors++;
        end
        if (m_axis_tdata[7] !== want.ignored) begin
          $error("ignored: expected %0d, got %0d", want.ignored, m_axis_tdata[7]);
          errors++;
        end
      end
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
      holds_done++;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
    end
  end

  initial begin
    #4000000;
    $display("** fisher_yates_shuffle_engine: FAILED **");
    $finish;
  end

  initial begin
    plan_row_t plan [28] = '{
      '{0, 2'd0, 7'd0,   ACT_READ,    31'd0,          6'd0,  1, 6'd0,  1'b1, 1'b0},
      '{0, 2'd0, 7'd0,   ACT_READ,    31'h7fffffff,   6'd63, 1, 6'd63, 1'b1, 1'b0},
      '{0, 2'd0, 7'd0,   ACT_STEP,    31'h7fffffff,   6'd63, 1, 6'd0,  1'b1, 1'b1},
      '{0, 2'd0, 7'd0,   ACT_UNUSED,  31'h2aaaaaaa,   6'h15, 1, 6'd0,  1'b1, 1'b0},
      '{0, 2'd0, 7'd0,   ACT_RESTART, 31'h55555555,   6'h2a, 1, 6'd0,  1'b0, 1'b0},
      '{0, 2'd0, 7'd0,   ACT_STEP,    31'd0,          6'd0,  0, 6'd0,  1'b0, 1'b0},
      '{0, 2'd0, 7'd0,   ACT_STEP,    31'h7fffffff,   6'd0,  0, 6'd0,  1'b0, 1'b0},
      '{0, 2'd0, 7'd0,   ACT_READ,    31'd0,          6'd53, 0, 6'd0,  1'b0, 1'b0},
      '{0, 2'd0, 7'd0,   ACT_UNUSED,  31'd0,          6'd0,  1, 6'd0,  1'b0, 1'b0},
      '{1, REG_DECK_SIZE, 7'd1, ACT_RESTART, 31'd0, 6'd0, 0, 6'd0, 1'b0, 1'b0},
      '{0, 2'd0, 7'd0,   ACT_STEP,    31'd5,          6'd0,  1, 6'd0,  1'b1, 1'b1},
      '{0, 2'd0, 7'd0,   ACT_RESTART, 31'd0,          6'd0,  1, 6'd0,  1'b0, 1'b0},
      '{0, 2'd0, 7'd0,   ACT_STEP,    31'h7fffffff,   6'd0,  0, 6'd0,  1'b0, 1'b0},
      '{0, 2'd0, 7'd0,   ACT_STEP,    31'd9,          6'd0,  1, 6'd0,  1'b1, 1'b1},
      '{1, REG_SHUFFLE_MODE,  7'd1, ACT_RESTART, 31'd0, 6'd0, 0, 6'd0, 1'b0, 1'b0},
      '{1, REG_PARTIAL_COUNT, 7'd0, ACT_RESTART, 31'd0, 6'd0, 0, 6'd0, 1'b0, 1'b0},
      '{0, 2'd0, 7'd0,   ACT_RESTART, 31'd0,          6'd0,  1, 6'd0,  1'b1, 1'b0},
      '{0, 2'd0, 7'd0,   ACT_STEP,    31'd1,          6'd0,  1, 6'd0,  1'b1, 1'b1},
      '{1, REG_DECK_SIZE,     7'd127, ACT_RESTART, 31'd0, 6'd0, 0, 6'd0, 1'b0, 1'b0},
      '{1, REG_PARTIAL_COUNT, 7'd127, ACT_RESTART, 31'd0, 6'd0, 0, 6'd0, 1'b0, 1'b0},
      '{0, 2'd0, 7'd0,   ACT_RESTART, 31'd0,          6'd0,  1, 6'd0,  1'b0, 1'b0},
      '{0, 2'd0, 7'd0,   ACT_STEP,    31'h7fffffff,   6'd0,  0, 6'd0,  1'b0, 1'b0},
      '{0, 2'd0, 7'd0,   ACT_READ,    31'd0,          6'd63, 0, 6'd0,  1'b0, 1'b0},
      '{1, REG_SHUFFLE_MODE, 7'h7e, ACT_RESTART, 31'd0, 6'd0, 0, 6'd0, 1'b0, 1'b0},
      '{0, 2'd0, 7'd0,   ACT_STEP,    31'd3,          6'd0,  0, 6'd0,  1'b0, 1'b0},
      '{0, 2'd0, 7'd0,   ACT_READ,    31'd0,          6'd1,  0, 6'd0,  1'b0, 1'b0},
      '{1, REG_UNUSED, 7'h7f, ACT_RESTART, 31'd0, 6'd0, 0, 6'd0, 1'b0, 1'b0},
      '{0, 2'd0, 7'd0,   ACT_READ,    31'd0,          6'd0,  0, 6'd0,  1'b0, 1'b0}
    };
    int phase;
    int start_items;
    int walk_len;
    int k;
    int w;
    bit pressure_done;
    logic [CFG_W-1:0] deck_val;
    logic [CFG_W-1:0] count_val;
    result_t typed_res;

    for (k = 0; k < MAX_ENTRIES; k++) perm_model[k] = k[ENTRY_W-1:0];
    walk_pos = 0;
    walk_done = 1'b1;
    deck_reg = DECK_SIZE_RST;
    mode_reg = 1'b0;
    count_reg = PARTIAL_COUNT_RST;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[r]) begin
      if (plan[r].is_cfg) begin
        write_register(plan[r].reg_idx, plan[r].reg_val);
      end else begin
        typed_res = '{entry: plan[r].entry, finished: plan[r].finished,
                      ignored: plan[r].ignored};
        send_request(plan[r].act, plan[r].rnd, plan[r].ridx, plan[r].typed, typed_res);
      end
    end

    for (phase = 0; phase < PHASES; phase++) begin
      send_gap_pct = (phase < 3) ? 13 : (phase < 6) ? 69 : 0;
      recv_gap_pct = (phase < 3) ? 69 : (phase < 6) ? 13 : 0;
      case ($urandom_range(0, 5))
        0: deck_val = 7'($urandom_range(0, 1));
        1: deck_val = 7'd2;
        2: deck_val = 7'd64;
        3: deck_val = 7'($urandom_range(65, 127));
        default: deck_val = 7'($urandom_range(2, 64));
      endcase
      case ($urandom_range(0, 4))
        0: count_val = 7'd0;
        1: count_val = 7'($urandom_range(65, 127));
        2: count_val = deck_val;
        default: count_val = 7'($urandom_range(1, 64));
      endcase
      write_register(REG_DECK_SIZE, deck_val);
      write_register(REG_SHUFFLE_MODE, {6'($urandom_range(0, 63)), phase[0]});
      write_register(REG_PARTIAL_COUNT, count_val);
      if ($urandom_range(0, 2) == 0) write_register(REG_UNUSED, 7'($urandom_range(0, 127)));

      start_items = accepted_items;
      pressure_done = 1'b0;
      while (accepted_items - start_items < PHASE_ITEMS) begin
        if (!pressure_done && accepted_items - start_items >= PHASE_ITEMS / 2) begin
          pressure_done = 1'b1;
          if (phase % 3 == 1) hold_req = 1'b1;
          else if (phase % 3 == 2) drain_requests();
        end
        if ($urandom_range(0, 99) < 80) begin
          send_request(ACT_RESTART, 31'($urandom), 6'($urandom), 0, '0);
          walk_len = mode_reg ? walk_limit(deck_entries()) : deck_entries() - 1;
          case ($urandom_range(0, 9))
            0: walk_len = $urandom_range(0, walk_len);
            1: walk_len = walk_len + $urandom_range(1, 3);
            default: ;
          endcase
          for (k = 0; k < walk_len; k++) begin
            if ($urandom_range(0, 4) == 0)
              send_request(ACT_READ, 31'($urandom), 6'($urandom_range(0, 63)), 0, '0);
            send_request(ACT_STEP, 31'($urandom), 6'($urandom), 0, '0);
          end
          repeat ($urandom_range(0, 3))
            send_request(ACT_READ, 31'($urandom), 6'($urandom_range(0, 63)), 0, '0);
        end else begin
          send_request(2'($urandom_range(0, 3)), 31'($urandom), 6'($urandom), 0, '0);
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    for (w = 0; w < DRAIN_LIMIT && owed_results.size() != 0; w++) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (owed_results.size() != 0) begin
      $error("%0d results never arrived", owed_results.size());
      errors++;
    end

    $display("run covered %0d requests (%0d swaps, %0d late steps), %0d results compared",
             accepted_items + ignored_steps, swaps_done, ignored_steps, results_checked);
    $display("over %0d register writes, %0d long output stalls, %0d mismatches",
             cfg_writes, holds_done, errors);
    if (errors == 0) begin
      $display("** fisher_yates_shuffle_engine: PASSED **");
    end else begin
      $display("** fisher_yates_shuffle_engine: FAILED **");
    end
    $finish;
  end

endmodule

/* fisher_yates_shuffle_engine.f */
+incdir+hdl
hdl/fys_pkg.sv
hdl/fys_modred.sv
hdl/fys_store.sv
hdl/fisher_yates_shuffle_engine.sv
bench/tb_fisher_yates_shuffle_engine.sv
